// File: sv/tscal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscal_pkg
// Shared types, sizes and codes of the transform slot cache allocator.
// ----------------------------------------------------------------------------
package tscal_pkg;

    // pool sizes
    localparam int SLOTS     = 256;
    localparam int OBJECTS   = 256;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int OBJ_AW    = $clog2(OBJECTS);
    localparam int CLR_DEPTH = (SLOTS > OBJECTS) ? SLOTS : OBJECTS;
    localparam int IDX_W     = $clog2(CLR_DEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_REQUEST    = 2'd0;
    localparam logic [1:0] OP_TICK       = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;

    // entry codes
    localparam logic [1:0]        AGE_FREE   = 2'd2;
    localparam logic signed [8:0] OWNER_NONE = -9'sd1;
    localparam logic [OBJ_AW:0]   OBJ_NONE   = '1;
    localparam logic [SLOT_AW:0]  SLOT_NONE  = '1;

    typedef struct packed {
        logic [1:0]        age;
        logic signed [8:0] owner;
        logic [OBJ_AW:0]   obj;    // all ones: no object bound
    } slot_entry_t;

    localparam slot_entry_t SLOT_ENTRY_FREE = '{age: AGE_FREE, owner: OWNER_NONE, obj: OBJ_NONE};

    typedef struct packed {
        logic        is_free;
        logic        owner_hit;
        logic        owned;
        logic        expires;
        slot_entry_t aged;
    } slot_eval_t;

    typedef struct packed {
        logic [7:0] slot_index;
        logic       needs_fill;
        logic       fallback_used;
    } result_t;

endpackage : tscal_pkg
`default_nettype wire

// File: sv/tscal_slot_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscal_slot_eval
// Shared slot unit: free test, owner compare and aging of one slot entry.
// ----------------------------------------------------------------------------
module tscal_slot_eval
    import tscal_pkg::*;
(
    input  slot_entry_t       entry,
    input  logic signed [8:0] region,
    output slot_eval_t        eval
);

    logic [2:0] age_sum;

    always_comb begin
        age_sum        = {1'b0, entry.age} + 3'd1;
        eval.is_free   = (entry.age >= AGE_FREE) && (entry.owner == OWNER_NONE);
        eval.owner_hit = (entry.owner == region);
        eval.owned     = !entry.owner[8];
        eval.expires   = eval.owned && (age_sum >= {1'b0, AGE_FREE});
        if (eval.expires) begin
            eval.aged = SLOT_ENTRY_FREE;
        end else if (eval.owned) begin
            eval.aged = '{age: age_sum[1:0], owner: entry.owner, obj: entry.obj};
        end else begin
            eval.aged = entry;
        end
    end

endmodule : tscal_slot_eval
`default_nettype wire

// File: sv/tscal_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscal_out_reg
// Result register: hold one finished transaction until the sink takes it.
// ----------------------------------------------------------------------------
module tscal_out_reg
    import tscal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    res_in,
    output logic       can_load,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_slot_index,
    output logic       m_needs_fill,
    output logic       m_fallback_used
);

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_valid         = valid_reg;
    assign m_slot_index    = data_reg.slot_index;
    assign m_needs_fill    = data_reg.needs_fill;
    assign m_fallback_used = data_reg.fallback_used;

endmodule : tscal_out_reg
`default_nettype wire

// File: sv/transform_slot_cache_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// transform_slot_cache_allocator_unit
// Maps objects onto a pool of transform slots: hit, first-free fill, aging, invalidate.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+-----------------
//  input   | in        | s_operation, s_object_id, s_viewer_region    | s_valid/s_ready
//  result  | out       | m_slot_index, m_needs_fill, m_fallback_used  | m_valid/m_ready
//
//  A request miss runs a first-free search that reads one slot per cycle
//  through the single read port of the slot memory; an aging tick sweeps
//  every slot, and invalidate runs a clearing pass over both tables.
//  After reset the same clearing pass over both tables runs with s_ready low.
//  One transaction is in work at a time; s_ready is high only in idle.
//  A finished result waits in the output register, so the next transaction
//  is taken while m_ready is low; only its own result then stalls.
// ----------------------------------------------------------------------------
module transform_slot_cache_allocator_unit
    import tscal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [7:0]        s_object_id,
    input  logic signed [8:0] s_viewer_region,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_slot_index,
    output logic              m_needs_fill,
    output logic              m_fallback_used
);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_OBJ_RD   = 4'd2;
    localparam logic [3:0] ST_OBJ_CHK  = 4'd3;
    localparam logic [3:0] ST_SLOT_RD  = 4'd4;
    localparam logic [3:0] ST_SLOT_CHK = 4'd5;
    localparam logic [3:0] ST_SEARCH   = 4'd6;
    localparam logic [3:0] ST_WRITE    = 4'd7;
    localparam logic [3:0] ST_AGE      = 4'd8;
    localparam logic [3:0] ST_RESULT   = 4'd9;

    // control state
    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               report_reg, report_next;

    // payload state
    logic [SLOT_AW-1:0] chk_idx_reg, chk_idx_next;
    logic [7:0]         obj_reg, obj_next;
    logic signed [8:0]  region_reg, region_next;
    logic [SLOT_AW-1:0] cur_slot_reg, cur_slot_next;
    logic [SLOT_AW-1:0] found_reg, found_next;
    logic               fb_reg, fb_next;
    result_t            res_reg, res_next;

    // memories: slot table and object-to-slot map
    slot_entry_t        slot_mem [SLOTS];
    logic [SLOT_AW:0]   objmap_mem [OBJECTS];
    slot_entry_t        slot_rdata_reg;
    logic [SLOT_AW:0]   objmap_rdata_reg;

    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    slot_entry_t        slot_wdata;
    logic [SLOT_AW-1:0] slot_raddr;
    logic               objmap_we;
    logic [OBJ_AW-1:0]  objmap_waddr;
    logic [SLOT_AW:0]   objmap_wdata;
    logic [OBJ_AW-1:0]  objmap_raddr;

    logic               issue;
    logic               obj_ok;
    logic               out_load;
    logic               out_can_load;
    slot_eval_t         ev;

    // Shared slot unit: evaluates the entry read in the previous cycle.
    tscal_slot_eval u_eval (
        .entry  (slot_rdata_reg),
        .region (region_reg),
        .eval   (ev)
    );

    tscal_out_reg u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (out_load),
        .res_in          (res_reg),
        .can_load        (out_can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_index    (m_slot_index),
        .m_needs_fill    (m_needs_fill),
        .m_fallback_used (m_fallback_used)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign obj_ok  = ({24'd0, s_object_id} < 32'(OBJECTS));
    // a sweep issues one read per cycle until every slot has been addressed
    assign issue   = (idx_reg < IDX_W'(SLOTS));

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
        if (objmap_we) begin
            objmap_mem[objmap_waddr] <= objmap_wdata;
        end
        objmap_rdata_reg <= objmap_mem[objmap_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        report_next    = report_reg;
        obj_next       = obj_reg;
        region_next    = region_reg;
        cur_slot_next  = cur_slot_reg;
        found_next     = found_reg;
        fb_next        = fb_reg;
        res_next       = res_reg;

        slot_we      = 1'b0;
        slot_waddr   = chk_idx_reg;
        slot_wdata   = ev.aged;
        slot_raddr   = idx_reg[SLOT_AW-1:0];
        objmap_we    = 1'b0;
        objmap_waddr = OBJ_AW'(obj_reg);
        objmap_wdata = SLOT_NONE;
        objmap_raddr = OBJ_AW'(obj_reg);
        out_load     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    obj_next    = s_object_id;
                    region_next = s_viewer_region;
                    res_next    = '0;
                    fb_next     = 1'b0;
                    idx_next    = '0;
                    chk_valid_next = 1'b0;
                    case (s_operation)
                        OP_REQUEST:    state_next = obj_ok ? ST_OBJ_RD : ST_RESULT;
                        OP_TICK:       state_next = ST_AGE;
                        OP_INVALIDATE: begin
                            report_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default:       state_next = ST_RESULT;
                    endcase
                end
            end

            // Sweep both tables back to their reset contents, one row a cycle.
            ST_CLEAR: begin
                slot_we      = (idx_reg < IDX_W'(SLOTS));
                slot_waddr   = idx_reg[SLOT_AW-1:0];
                slot_wdata   = SLOT_ENTRY_FREE;
                objmap_we    = (idx_reg < IDX_W'(OBJECTS));
                objmap_waddr = idx_reg[OBJ_AW-1:0];
                objmap_wdata = SLOT_NONE;
                idx_next     = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(CLR_DEPTH - 1)) begin
                    report_next = 1'b0;
                    state_next  = report_reg ? ST_RESULT : ST_IDLE;
                end
            end

            ST_OBJ_RD: begin
                state_next = ST_OBJ_CHK;
            end

            // No slot on record: go straight to the free-slot search; else read that slot.
            ST_OBJ_CHK: begin
                if (objmap_rdata_reg[SLOT_AW]) begin
                    state_next = ST_SEARCH;
                end else begin
                    cur_slot_next = objmap_rdata_reg[SLOT_AW-1:0];
                    state_next    = ST_SLOT_RD;
                end
            end

            ST_SLOT_RD: begin
                slot_raddr = cur_slot_reg;
                state_next = ST_SLOT_CHK;
            end

            // Hit refreshes the age; a miss unbinds the old slot and searches.
            ST_SLOT_CHK: begin
                slot_we    = 1'b1;
                slot_waddr = cur_slot_reg;
                if (ev.owner_hit) begin
                    slot_wdata = '{age: 2'd0, owner: slot_rdata_reg.owner,
                                   obj: slot_rdata_reg.obj};
                    res_next   = '{slot_index: 8'(cur_slot_reg), needs_fill: 1'b0,
                                   fallback_used: 1'b0};
                    state_next = ST_RESULT;
                end else begin
                    slot_wdata = '{age: slot_rdata_reg.age, owner: slot_rdata_reg.owner,
                                   obj: OBJ_NONE};
                    state_next = ST_SEARCH;
                end
            end

            // Read slot idx while testing the slot read in the previous cycle.
            ST_SEARCH: begin
                chk_valid_next = issue;
                chk_idx_next   = idx_reg[SLOT_AW-1:0];
                if (issue) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (chk_valid_reg && ev.is_free) begin
                    found_next = chk_idx_reg;
                    fb_next    = 1'b0;
                    state_next = ST_WRITE;
                end else if (!chk_valid_reg && !issue) begin
                    found_next = '0;
                    fb_next    = 1'b1;
                    state_next = ST_WRITE;
                end
            end

            // Bind the chosen slot and the object to each other.
            ST_WRITE: begin
                slot_we      = 1'b1;
                slot_waddr   = found_reg;
                slot_wdata   = '{age: 2'd0, owner: region_reg,
                                 obj: {1'b0, OBJ_AW'(obj_reg)}};
                objmap_we    = 1'b1;
                objmap_wdata = {1'b0, found_reg};
                res_next     = '{slot_index: 8'(found_reg), needs_fill: 1'b1,
                                 fallback_used: fb_reg};
                state_next   = ST_RESULT;
            end

            // Age owned slots; an expiring slot also drops its object's pointer.
            ST_AGE: begin
                chk_valid_next = issue;
                chk_idx_next   = idx_reg[SLOT_AW-1:0];
                if (issue) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (chk_valid_reg && ev.owned) begin
                    slot_we = 1'b1;
                    if (ev.expires && !slot_rdata_reg.obj[OBJ_AW]) begin
                        objmap_we    = 1'b1;
                        objmap_waddr = slot_rdata_reg.obj[OBJ_AW-1:0];
                    end
                end
                if (!chk_valid_reg && !issue) begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT: begin
                if (out_can_load) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reset starts the clearing pass; it ends in idle without a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            report_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            report_reg    <= report_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg  <= chk_idx_next;
        obj_reg      <= obj_next;
        region_reg   <= region_next;
        cur_slot_reg <= cur_slot_next;
        found_reg    <= found_next;
        fb_reg       <= fb_next;
        res_reg      <= res_next;
    end

    // Never overwrite a result the sink has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten while held");

    // Ready drops after every accepted transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready high right after an accepted transaction");

    // A fallback always binds slot 0.
    a_fallback_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && fb_reg) |-> (found_reg == '0))
        else $error("fallback did not take slot 0");

    // The object map is written only by clearing, aging or binding.
    a_objmap_write: assert property (@(posedge aclk) disable iff (!aresetn)
        objmap_we |-> (state_reg == ST_CLEAR || state_reg == ST_AGE ||
                       state_reg == ST_WRITE))
        else $error("object map written outside clear, age or bind");

endmodule : transform_slot_cache_allocator_unit
`default_nettype wire
